// File: design/ssr_pkg.sv
// Shared types and constants for the servo slew ramp controller.
// No dependencies; imported by the core, controller, datapath and divider.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  // Input operation codes
  typedef enum logic [2:0] {
    OP_JUMP  = 3'd0,
    OP_SLOW  = 3'd1,
    OP_TIMED = 3'd2,
    OP_STEP  = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_ANGLE = 2'd0,
    CFG_MAX_ANGLE = 2'd1,
    CFG_REVERSE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL,
    ST_QUOT,
    ST_GOAL,
    ST_IDIV_GO,
    ST_IDIV_WAIT,
    ST_INTV,
    ST_DONE
  } state_e;

  localparam int unsigned DivNumW = 16;
  localparam int unsigned DivDenW = 9;

  // x / 25 == (x * GoalRecip) >> 17 for x below 43690
  localparam logic [12:0]        GoalRecip   = 13'd5243;
  localparam logic [16:0]        CntMax      = 17'h1FFFF;
  localparam logic signed [7:0]  MinMinAngle = -8'sd70;
  localparam logic signed [7:0]  MaxAngleRst = 8'sd70;
  localparam logic signed [7:0]  JumpLo      = -8'sd90;
  localparam logic signed [7:0]  JumpHi      = 8'sd90;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic quot_en;
    logic goal_en;
    logic div_start;
    logic intv_en;
    logic commit;
  } ssr_cmd_t;

  typedef struct packed {
    logic start_ok;
    logic timed;
    logic div_done;
    logic out_free;
  } ssr_sts_t;

endpackage

`default_nettype wire

// File: design/servo_slew_ramp_controller_core.sv
// Servo slew ramp controller, one channel: top level joining controller
// and datapath. Depends on ssr_pkg, ssr_ctrl, ssr_datapath.
// Sequence for jump, step, tick and a refused start: accept, decode, commit.
// An accepted slow move adds multiply, quotient and goal states; a timed move
// also adds one divider pass. One item in flight, next taken the cycle after
// the result is registered; the commit waits while the output is stalled.
// Reset (rst_ni low, async): angle, goal, interval and counter cleared,
// min/max angle -70/70, direction normal, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module servo_slew_ramp_controller_core
  import ssr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [2:0] operation
  input  wire logic [2:0]  s_axis_tuser,
  // [7:0] value, [23:8] duration_ms
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] accepted, [1] arrived, [2] command_valid, [10:3] servo_command,
  // [18:11] current_angle, [19] moving, [23:20] zero
  output logic [23:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  ssr_cmd_t cmd;
  ssr_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ssr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ssr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tready_i  (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tdata_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: design/ssr_div.sv
// Unsigned 16 / 9 bit restoring divider, two quotient bits per cycle.
// Depends on ssr_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module ssr_div
  import ssr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DivNumW-1:0] num_i,
  input  wire logic [DivDenW-1:0] den_i,
  output logic                    done_o,
  output logic      [DivNumW-1:0] quo_o
);

  localparam int unsigned CntW = $clog2(DivNumW / 2);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;

  logic [DivDenW:0]   r1, r2;
  logic [DivDenW-1:0] rem1;
  logic               b1, b2;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;

    // two restoring steps; remainder always stays below the divisor
    r1   = {rem_q, quo_q[DivNumW-1]};
    b1   = (r1 >= {1'b0, den_q});
    rem1 = b1 ? DivDenW'(r1 - {1'b0, den_q}) : r1[DivDenW-1:0];
    r2   = {rem1, quo_q[DivNumW-2]};
    b2   = (r2 >= {1'b0, den_q});

    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = b2 ? DivDenW'(r2 - {1'b0, den_q}) : r2[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-3:0], b1, b2};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivNumW / 2 - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: design/ssr_datapath.sv
// Datapath: configuration and ramp state, goal mapping multiplier, interval
// divider, servo command math and the output register. Uses ssr_pkg, ssr_div.
`timescale 1ns / 1ps
`default_nettype none

module ssr_datapath
  import ssr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  s_tuser_i,
  input  wire logic [23:0] s_tdata_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        m_tready_i,
  input  wire ssr_cmd_t    cmd_i,
  output ssr_sts_t         sts_o,
  output logic             m_tvalid_o,
  output logic [23:0]      m_tdata_o
);

  // configuration
  logic signed [7:0] min_q, max_q;
  logic              rev_q;

  // ramp state
  logic signed [7:0] now_q, now_d;
  logic signed [7:0] goal_q, goal_d;
  logic              active_q, active_d;
  logic [16:0]       intv_q, intv_d;
  logic [16:0]       cnt_q, cnt_d;

  // captured item and intermediates
  logic [2:0]         op_q;
  logic signed [7:0]  val_q;
  logic [15:0]        dur_q;
  logic signed [17:0] prod_q;
  logic [8:0]         quot_q;
  logic signed [7:0]  gnew_q;
  logic [16:0]        inew_q;

  // output register
  logic        ovalid_q;
  logic [23:0] odata_q, odata_d;

  // goal mapping
  logic signed [8:0]  ratio_s, span_s;
  logic signed [17:0] prod_d;
  logic [17:0]        prod_mag;
  logic [25:0]        qprod;
  logic signed [10:0] qs, tq, graw, min11, max11;
  logic signed [7:0]  gclamp;

  // divider
  logic [DivNumW-1:0] div_quo;
  logic               div_done;
  logic signed [8:0]  diff_s;
  logic [8:0]         diff_abs, dist_p1;

  // commit
  logic [16:0]        cnt_inc;
  logic               acc, arr, cmd, do_step;
  logic signed [8:0]  sum_s, sum_adj;
  logic signed [8:0]  half_s;
  logic signed [10:0] center, ang11, cval;
  logic [7:0]         servo;

  // config writes; index 3 is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinMinAngle;
      max_q <= MaxAngleRst;
      rev_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_ANGLE: min_q <= cfg_data_i;
        CFG_MAX_ANGLE: max_q <= cfg_data_i;
        CFG_REVERSE:   rev_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // (ratio + 100) * (max - min), then |product| / 200 as (m >> 3) / 25
  always_comb begin
    ratio_s = {val_q[7], val_q} + 9'sd100;
    span_s  = {max_q[7], max_q} - {min_q[7], min_q};
    prod_d  = ratio_s * span_s;
    prod_mag = prod_q[17] ? 18'(-prod_q) : 18'(prod_q);
    qprod   = {13'd0, prod_mag[15:3]} * {13'd0, GoalRecip};
  end

  // truncating quotient back to a signed goal, then range limit
  always_comb begin
    qs    = $signed({2'b00, quot_q});
    tq    = prod_q[17] ? -qs : qs;
    min11 = {{3{min_q[7]}}, min_q};
    max11 = {{3{max_q[7]}}, max_q};
    graw  = tq + min11;
    if (graw < min11)      gclamp = min_q;
    else if (graw > max11) gclamp = max_q;
    else                   gclamp = graw[7:0];
  end

  // timed interval divisor |goal - now| + 1
  always_comb begin
    diff_s   = {gnew_q[7], gnew_q} - {now_q[7], now_q};
    diff_abs = diff_s[8] ? 9'(-diff_s) : 9'(diff_s);
    dist_p1  = diff_abs + 9'd1;
  end

  ssr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (dur_q),
    .den_i   (dist_p1),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= s_tuser_i;
      val_q <= s_tdata_i[7:0];
      dur_q <= s_tdata_i[23:8];
    end
    if (cmd_i.mul_en)  prod_q <= prod_d;
    if (cmd_i.quot_en) quot_q <= qprod[25:17];
    if (cmd_i.goal_en) gnew_q <= gclamp;
    if (cmd_i.intv_en) inew_q <= {1'b0, div_quo} + 17'd1;
  end

  // item effect on the ramp state
  always_comb begin
    now_d    = now_q;
    goal_d   = goal_q;
    active_d = active_q;
    intv_d   = intv_q;
    cnt_d    = cnt_q;
    acc      = 1'b0;
    arr      = 1'b0;
    cmd      = 1'b0;
    do_step  = 1'b0;
    cnt_inc  = (cnt_q == CntMax) ? cnt_q : cnt_q + 17'd1;

    unique case (op_q)
      OP_JUMP: begin
        if (val_q < JumpLo)      now_d = JumpLo;
        else if (val_q > JumpHi) now_d = JumpHi;
        else                     now_d = val_q;
        cmd = 1'b1;
      end
      OP_SLOW, OP_TIMED: begin
        if (!active_q) begin
          active_d = 1'b1;
          goal_d   = gnew_q;
          if (op_q == OP_TIMED) intv_d = inew_q;
          acc = 1'b1;
        end
      end
      OP_STEP: do_step = 1'b1;
      OP_TICK: begin
        if (cnt_inc > intv_q) begin
          cnt_d   = '0;
          do_step = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: ;
    endcase

    if (do_step && active_q) begin
      if (goal_q < now_q) begin
        now_d = now_q - 8'sd1;
        cmd   = 1'b1;
      end else if (goal_q > now_q) begin
        now_d = now_q + 8'sd1;
        cmd   = 1'b1;
      end else begin
        active_d = 1'b0;
        arr      = 1'b1;
      end
    end
  end

  // servo command: center = 90 + (max + min) / 2 toward zero, saturated
  always_comb begin
    sum_s   = {max_q[7], max_q} + {min_q[7], min_q};
    sum_adj = sum_s + (sum_s[8] ? 9'sd1 : 9'sd0);
    half_s  = sum_adj >>> 1;
    center  = 11'sd90 + {{2{half_s[8]}}, half_s};
    ang11   = {{3{now_d[7]}}, now_d};
    cval    = rev_q ? center - ang11 : center + ang11;
    if (cval < 11'sd0)        servo = 8'd0;
    else if (cval > 11'sd180) servo = 8'd180;
    else                      servo = cval[7:0];
    odata_d = {4'b0000, active_d, now_d, (cmd ? servo : 8'd0), cmd, arr, acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q    <= '0;
      goal_q   <= '0;
      active_q <= 1'b0;
      intv_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        now_q    <= now_d;
        goal_q   <= goal_d;
        active_q <= active_d;
        intv_q   <= intv_d;
        cnt_q    <= cnt_d;
        ovalid_q <= 1'b1;
      end else if (m_tready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) odata_q <= odata_d;
  end

  assign sts_o.start_ok = ((op_q == OP_SLOW) || (op_q == OP_TIMED)) && !active_q;
  assign sts_o.timed    = (op_q == OP_TIMED);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovalid_q || m_tready_i;

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = odata_q;

endmodule

`default_nettype wire

// File: design/ssr_ctrl.sv
// Controller state machine sequencing capture, goal mapping, the interval
// divider pass and the commit. Uses ssr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssr_ctrl
  import ssr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     s_tvalid_i,
  output logic          s_tready_o,
  input  wire ssr_sts_t sts_i,
  output ssr_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: state_d = sts_i.start_ok ? ST_MUL : ST_DONE;
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_QUOT;
      end
      ST_QUOT: begin
        cmd_o.quot_en = 1'b1;
        state_d       = ST_GOAL;
      end
      ST_GOAL: begin
        cmd_o.goal_en = 1'b1;
        state_d       = sts_i.timed ? ST_IDIV_GO : ST_DONE;
      end
      ST_IDIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_IDIV_WAIT;
      end
      ST_IDIV_WAIT: if (sts_i.div_done) state_d = ST_INTV;
      ST_INTV: begin
        cmd_o.intv_en = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: design/ssr_checker.sv
// Port-level checks on the result stream of the servo slew ramp controller.
// Bound to servo_slew_ramp_controller_core; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ssr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[10:3] <= 8'd180)
    else $error("servo command above 180");

  a_nocmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[10:3] == 8'd0)
    else $error("servo command without command_valid");

  a_arrive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[19] && !m_axis_tdata[2]
      && !m_axis_tdata[0])
    else $error("arrival still moving or issuing a command");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[19] && !m_axis_tdata[2])
    else $error("accepted start not moving");

endmodule

bind servo_slew_ramp_controller_core ssr_checker u_ssr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
